>>> src/cbse_pkg.sv
`timescale 1ns / 1ps

package cbse_pkg;

    // Coordinate and glyph geometry
    localparam int COORD_BITS    = 16;
    localparam int MAX_GLYPH_DIM = 4096;
    localparam int DIM_W         = 13;
    localparam int COLOUR_W      = 16;
    localparam int PIX_W         = 8;
    localparam int BIT_W         = $clog2(PIX_W);
    localparam int ROW_W         = $clog2(MAX_GLYPH_DIM);
    localparam int COL_W         = ROW_W - BIT_W;

    // Internal arithmetic widths: counts and unclipped coordinates
    localparam int MW1 = (ROW_W > DIM_W) ? ROW_W : DIM_W;
    localparam int CW  = MW1 + 1;
    localparam int XW  = ((COORD_BITS > MW1) ? COORD_BITS : MW1) + 2;

    // Span bookkeeping: closes per byte (one per bit plus row end)
    localparam int MAX_OUT = 4;
    localparam int SLOTS   = MAX_OUT + 1;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CAND    = PIX_W + 1;
    localparam int N_W     = $clog2(CAND + 2);
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // Config register reset values
    localparam logic [COORD_BITS-1:0] CLIP_HI_RST = COORD_BITS'(32767);

    // Config register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT    = 3'd0,
        CFG_CLIP_RIGHT   = 3'd1,
        CFG_CLIP_TOP     = 3'd2,
        CFG_CLIP_BOTTOM  = 3'd3,
        CFG_CLIP_DISABLE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] clip_left;
        logic signed [COORD_BITS-1:0] clip_right;
        logic signed [COORD_BITS-1:0] clip_top;
        logic signed [COORD_BITS-1:0] clip_bottom;
        logic                         clip_disable;
    } t_cfg;

    typedef struct packed {
        logic        [PIX_W-1:0]      pixel_byte;
        logic signed [COORD_BITS-1:0] glyph_left;
        logic signed [COORD_BITS-1:0] glyph_bottom;
        logic        [DIM_W-1:0]      glyph_width;
        logic        [DIM_W-1:0]      glyph_height;
        logic        [COLOUR_W-1:0]   colour;
        logic                         first_byte;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] span_start_x;
        logic signed [COORD_BITS-1:0] span_end_x;
        logic signed [COORD_BITS-1:0] span_y;
        logic        [COLOUR_W-1:0]   span_colour;
        logic                         last;
    } t_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] y;
        logic [COLOUR_W-1:0]   colour;
    } t_span;

    // Walker state carried from byte to byte
    typedef struct packed {
        logic [COL_W-1:0]      byte_column;
        logic [ROW_W-1:0]      row_index;
        logic                  run_active;
        logic [COORD_BITS-1:0] run_start;
        logic                  glyph_rejected;
        logic                  held_valid;
        t_span                 held;
    } t_state;

    // Spans produced by one byte, in order
    typedef struct packed {
        t_span [MAX_OUT-1:0] spans;
        logic  [CNT_W-1:0]   cnt;
    } t_group;

    // Sign-extend a coordinate into the wide compare domain
    function automatic logic signed [XW-1:0] sext_x(input logic [COORD_BITS-1:0] v);
        return $signed({{(XW-COORD_BITS){v[COORD_BITS-1]}}, v});
    endfunction

endpackage

>>> src/cbse_cfg.sv
`timescale 1ns / 1ps

module cbse_cfg import cbse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Writes are always accepted: o_cfg_ready is tied high
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Clip register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left    <= '0;
            r_cfg.clip_right   <= CLIP_HI_RST;
            r_cfg.clip_top     <= '0;
            r_cfg.clip_bottom  <= CLIP_HI_RST;
            r_cfg.clip_disable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CLIP_LEFT:    r_cfg.clip_left    <= i_cfg_data;
                CFG_CLIP_RIGHT:   r_cfg.clip_right   <= i_cfg_data;
                CFG_CLIP_TOP:     r_cfg.clip_top     <= i_cfg_data;
                CFG_CLIP_BOTTOM:  r_cfg.clip_bottom  <= i_cfg_data;
                CFG_CLIP_DISABLE: r_cfg.clip_disable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/cbse_row.sv
`timescale 1ns / 1ps

module cbse_row import cbse_pkg::*; (
    input  t_in    i_item,
    input  t_cfg   i_cfg,
    input  t_state i_state,
    output t_state o_state,
    output t_group o_group
);

    logic [DIM_W-1:0]      w_c, h_c;
    logic [CW-1:0]         wq, hq, bpr;
    logic                  en, first;
    logic signed [XW-1:0]  gl, gb, cl, cr, ct, cb, wx, hx, rx;
    logic signed [XW-1:0]  x2, y1, y, x2_last;
    logic [COL_W-1:0]      col0;
    logic [ROW_W-1:0]      row0;
    logic                  act0, rej0, rej1, proc, row_end, last_row, yvis;
    logic [PIX_W:0]        act;
    logic [COORD_BITS-1:0] st [PIX_W+1];
    logic signed [XW-1:0]  xb [PIX_W];
    logic signed [XW-1:0]  xe [PIX_W];
    logic [PIX_W-1:0]      valid, on;
    logic [CAND-1:0]       cand;
    t_span                 cspan [CAND];
    t_span                 slot  [SLOTS];
    logic [N_W-1:0]        pos;

    // Clamp dimensions and widen operands
    always_comb begin
        w_c   = (int'(i_item.glyph_width) > MAX_GLYPH_DIM) ?
                DIM_W'(MAX_GLYPH_DIM) : i_item.glyph_width;
        h_c   = (int'(i_item.glyph_height) > MAX_GLYPH_DIM) ?
                DIM_W'(MAX_GLYPH_DIM) : i_item.glyph_height;
        wq    = CW'(w_c);
        hq    = CW'(h_c);
        bpr   = (wq + CW'(PIX_W - 1)) >> BIT_W;
        en    = !i_cfg.clip_disable;
        first = i_item.first_byte;
        gl    = sext_x(i_item.glyph_left);
        gb    = sext_x(i_item.glyph_bottom);
        cl    = sext_x(i_cfg.clip_left);
        cr    = sext_x(i_cfg.clip_right);
        ct    = sext_x(i_cfg.clip_top);
        cb    = sext_x(i_cfg.clip_bottom);
        wx    = $signed({{(XW-DIM_W){1'b0}}, w_c});
        hx    = $signed({{(XW-DIM_W){1'b0}}, h_c});
        x2    = gl + wx - XW'(1);
        y1    = gb - hx + XW'(1);
    end

    // Glyph start, rejection and row position
    always_comb begin
        col0     = first ? '0 : i_state.byte_column;
        row0     = first ? '0 : i_state.row_index;
        act0     = first ? 1'b0 : i_state.run_active;
        rej0     = first ? ((w_c == '0) || (h_c == '0) ||
                            (en && ((gl >= cr) || (x2 < cl) || (y1 >= cb) || (gb < ct))))
                         : i_state.glyph_rejected;
        rej1     = rej0 || (CW'(row0) >= hq);
        proc     = !rej1;
        row_end  = (CW'(col0) + CW'(1)) >= bpr;
        last_row = (CW'(row0) + CW'(1)) >= hq;
        rx       = $signed({{(XW-ROW_W){1'b0}}, row0});
        y        = y1 + rx;
        yvis     = !en || ((y >= ct) && (y < cb));
        x2_last  = x2;
    end

    // Run tracking across the eight pixels, MSB first
    always_comb begin
        act[0] = act0;
        st[0]  = i_state.run_start;
        for (int b = 0; b < PIX_W; b++) begin
            xb[b]    = gl + $signed({{(XW-ROW_W){1'b0}}, col0, BIT_W'(b)});
            xe[b]    = xb[b] - XW'(1);
            valid[b] = CW'({col0, BIT_W'(b)}) < wq;
            on[b]    = valid[b] && i_item.pixel_byte[PIX_W-1-b] && yvis &&
                       (!en || ((xb[b] >= cl) && (xb[b] < cr)));
            cand[b]  = proc && valid[b] && !on[b] && act[b];
            cspan[b] = '{sx: st[b], ex: xe[b][COORD_BITS-1:0], y: y[COORD_BITS-1:0],
                         colour: i_item.colour};
            act[b+1] = valid[b] ? on[b] : act[b];
            st[b+1]  = (on[b] && !act[b]) ? xb[b][COORD_BITS-1:0] : st[b];
        end
        // Row end closes an open run at the glyph's right edge
        cand[PIX_W]  = proc && row_end && act[PIX_W];
        cspan[PIX_W] = '{sx: st[PIX_W], ex: x2_last[COORD_BITS-1:0],
                         y: y[COORD_BITS-1:0], colour: i_item.colour};
    end

    // Pack held span and new closes into order; fifth one is held over
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            slot[k] = '0;
        end
        pos = '0;
        if (i_state.held_valid) begin
            slot[0] = i_state.held;
            pos     = N_W'(1);
        end
        for (int i = 0; i < CAND; i++) begin
            if (cand[i]) begin
                if (pos < N_W'(SLOTS)) begin
                    slot[pos[SLOT_W-1:0]] = cspan[i];
                end
                pos = pos + N_W'(1);
            end
        end
        for (int k = 0; k < MAX_OUT; k++) begin
            o_group.spans[k] = slot[k];
        end
        o_group.cnt = (pos > N_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : pos[CNT_W-1:0];
    end

    // Next walker state
    always_comb begin
        o_state.byte_column    = proc ? (row_end ? '0 : col0 + COL_W'(1)) : col0;
        o_state.row_index      = (proc && row_end && !last_row) ? row0 + ROW_W'(1) : row0;
        o_state.glyph_rejected = rej1 || (proc && row_end && last_row);
        o_state.run_active     = proc ? (!row_end && act[PIX_W]) : act0;
        o_state.run_start      = proc ? st[PIX_W] : i_state.run_start;
        o_state.held_valid     = pos > N_W'(MAX_OUT);
        o_state.held           = slot[MAX_OUT];
    end

endmodule

>>> src/cbse_out.sv
`timescale 1ns / 1ps

module cbse_out import cbse_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_group i_group,
    input  logic   i_out_stall,
    output logic   o_free,
    output logic   o_out_valid,
    output t_out   o_out
);

    t_span            r_span [MAX_OUT];
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign o_free      = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && !i_out_stall);
    assign o_out_valid = r_cnt != '0;

    // Head of the group drives the port
    assign o_out.span_start_x = r_span[0].sx;
    assign o_out.span_end_x   = r_span[0].ex;
    assign o_out.span_y       = r_span[0].y;
    assign o_out.span_colour  = r_span[0].colour;
    assign o_out.last         = r_cnt == CNT_W'(1);

    // Span count of the group in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Span payload: load a group, shift down on each request taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                r_span[k] <= i_group.spans[k];
            end
        end else if (pop) begin
            for (int k = 0; k < MAX_OUT - 1; k++) begin
                r_span[k] <= r_span[k+1];
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_OUT))
        else $error("span group count above limit");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("group loaded over spans still pending");

    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_cnt > CNT_W'(1)) && !i_load) |=> o_out_valid)
        else $error("group ended before its last span");
`endif

endmodule

>>> src/clipped_bitmap_span_extractor.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_in  (t_in: one bitmap byte)
// out       output     o_out_valid / i_out_stall o_out (t_out: one span)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A byte sits in the input register, then moves into the output group register as soon
// as the previous group's last span is taken; its first span then shows from the output
// group register. A byte closing k spans (0..4) keeps the output group until its k spans
// are taken, while the next byte waits in the input register, so one byte per cycle is
// sustained while bytes close at most one span each and i_out_stall stays low.
// Reset (i_rst_n low, synchronous) clears walker state, output group and clip regs.
// o_in_stall rises while a byte waits for the output group to drain.

module clipped_bitmap_span_extractor import cbse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    t_cfg   cfg;
    t_in    r_in;
    logic   r_in_valid;
    t_state r_state;
    t_state n_state;
    t_group n_group;
    logic   out_free;
    logic   advance;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    cbse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register control and walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Input payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    cbse_row u_row (
        .i_item  (r_in),
        .i_cfg   (cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_group (n_group)
    );

    cbse_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_group     (n_group),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

>>> tb/sv/span_checker.sv
`timescale 1ns / 1ps

// Watches the request, span and register channels of the span extractor,
// predicts the spans of every accepted request and compares them in order.
module span_checker import cbse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // A byte closes at most one span per bit plus the row end, plus a held one
    localparam int SPAN_BUF = MAX_OUT + 2;

    // Clip registers as last written
    logic signed [COORD_BITS-1:0] clip_left;
    logic signed [COORD_BITS-1:0] clip_right;
    logic signed [COORD_BITS-1:0] clip_top;
    logic signed [COORD_BITS-1:0] clip_bottom;
    logic                         clip_off;

    // Walker state
    longint col_idx;
    longint row_idx;
    bit     in_run;
    longint run_x;
    bit     dropped;
    bit     held_ok;
    t_span  held_span;

    t_out   span_q[$];
    int     fails;

    // Walk one bitmap byte and queue the spans it closes
    function automatic void walk_byte(input t_in b);
        longint gl;
        longint gb;
        longint w;
        longint h;
        longint y;
        longint bpr;
        longint c;
        longint x;
        longint cl;
        longint cr;
        longint ct;
        longint cb;
        bit     en;
        bit     yvis;
        bit     row_end;
        bit     vis;
        bit     ink;
        int     emit;
        t_span  found[$];
        t_out   o;

        gl = $signed(b.glyph_left);
        gb = $signed(b.glyph_bottom);
        w  = b.glyph_width;
        h  = b.glyph_height;
        cl = clip_left;
        cr = clip_right;
        ct = clip_top;
        cb = clip_bottom;
        en = !clip_off;

        // span left over from the previous byte goes out first
        if (held_ok) begin
            found.push_back(held_span);
            held_ok = 1'b0;
        end
        if (w > MAX_GLYPH_DIM) w = MAX_GLYPH_DIM;
        if (h > MAX_GLYPH_DIM) h = MAX_GLYPH_DIM;

        // new glyph: restart and decide whole-glyph rejection
        if (b.first_byte) begin
            col_idx = 0;
            row_idx = 0;
            in_run  = 1'b0;
            dropped = (w == 0 || h == 0) ||
                      (en && (gl >= cr || gl + w - 1 < cl || gb - h + 1 >= cb || gb < ct));
        end
        if (!dropped && row_idx >= h) dropped = 1'b1;

        if (!dropped) begin
            y       = gb - h + 1 + row_idx;
            yvis    = !en || (y >= ct && y < cb);
            bpr     = (w + PIX_W - 1) / PIX_W;
            row_end = col_idx + 1 >= bpr;

            // scan bits from the glyph's own left edge
            for (int i = 0; i < PIX_W; i++) begin
                c = col_idx * PIX_W + i;
                if (c >= w) break;
                x   = gl + c;
                vis = yvis && (!en || (x >= cl && x < cr));
                ink = b.pixel_byte[PIX_W-1-i];
                if (ink && vis) begin
                    if (!in_run) begin
                        in_run = 1'b1;
                        run_x  = x;
                    end
                end else if (in_run) begin
                    if (found.size() < SPAN_BUF)
                        found.push_back('{16'(run_x), 16'(x - 1), 16'(y), b.colour});
                    in_run = 1'b0;
                end
            end

            // row end closes any open run at the glyph's right edge
            if (row_end) begin
                if (in_run && found.size() < SPAN_BUF)
                    found.push_back('{16'(run_x), 16'(gl + w - 1), 16'(y), b.colour});
                in_run  = 1'b0;
                col_idx = 0;
                if (row_idx + 1 >= h)
                    dropped = 1'b1;
                else
                    row_idx++;
            end else begin
                col_idx++;
            end
        end

        // at most four spans per byte; one more waits for the next byte
        emit = (found.size() < MAX_OUT) ? found.size() : MAX_OUT;
        if (found.size() > MAX_OUT) begin
            held_span = found[MAX_OUT];
            held_ok   = 1'b1;
        end
        for (int k = 0; k < emit; k++) begin
            o.span_start_x = found[k].sx;
            o.span_end_x   = found[k].ex;
            o.span_y       = found[k].y;
            o.span_colour  = found[k].colour;
            o.last         = (k == emit - 1);
            span_q.push_back(o);
        end
    endfunction

    function automatic int field_diff(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got === want) return 0;
        $display("%0t: span %s mismatch, expected %h actual %h", $time, name, want, got);
        return 1;
    endfunction

    // Compare first, then take register writes and new requests
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clip_left   = '0;
            clip_right  = CLIP_HI_RST;
            clip_top    = '0;
            clip_bottom = CLIP_HI_RST;
            clip_off    = 1'b0;
            col_idx     = 0;
            row_idx     = 0;
            in_run      = 1'b0;
            run_x       = 0;
            dropped     = 1'b0;
            held_ok     = 1'b0;
            held_span   = '0;
            span_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (span_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected span, expected none actual %h", $time, i_out);
                end else begin
                    want = span_q.pop_front();
                    fails += field_diff("start_x", want.span_start_x, i_out.span_start_x);
                    fails += field_diff("end_x", want.span_end_x, i_out.span_end_x);
                    fails += field_diff("y", want.span_y, i_out.span_y);
                    fails += field_diff("colour", want.span_colour, i_out.span_colour);
                    fails += field_diff("last", 16'(want.last), 16'(i_out.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CLIP_LEFT:    clip_left   = i_cfg_data;
                    CFG_CLIP_RIGHT:   clip_right  = i_cfg_data;
                    CFG_CLIP_TOP:     clip_top    = i_cfg_data;
                    CFG_CLIP_BOTTOM:  clip_bottom = i_cfg_data;
                    CFG_CLIP_DISABLE: clip_off    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) walk_byte(i_in);
        end
        o_fail_count <= fails;
        o_pending    <= span_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cbse_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DIM_MAX     = (1 << DIM_W) - 1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COORD_BITS-1:0] i_cfg_data  = '0;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    int  sent   = 0;
    bit  calm   = 1'b0;

    clipped_bitmap_span_extractor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    span_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Span receiver stalls at random, never while calm
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 21);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("clipped_bitmap_span_extractor test failed");
            $finish;
        end
    end

    function automatic t_in mk(input logic [7:0] pix, input longint gl, input longint gb,
                               input int w, input int h, input logic [15:0] col,
                               input bit first);
        t_in b;
        b.pixel_byte   = pix;
        b.glyph_left   = 16'(gl);
        b.glyph_bottom = 16'(gb);
        b.glyph_width  = 13'(w);
        b.glyph_height = 13'(h);
        b.colour       = col;
        b.first_byte   = first;
        return b;
    endfunction

    // Dense patterns close the most spans per byte
    function automatic logic [7:0] pick_pixels();
        case ($urandom_range(5))
            0:       return 8'h55;
            1:       return 8'hAA;
            2:       return 8'hFF;
            3:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // One request, with a random gap in front unless calm
    task automatic send_byte(input t_in b);
        if (!calm && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input logic [COORD_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_regs(input logic [15:0] l, input logic [15:0] r,
                              input logic [15:0] t, input logic [15:0] bt, input bit dis);
        cfg_put(CFG_CLIP_LEFT, l);
        cfg_put(CFG_CLIP_RIGHT, r);
        cfg_put(CFG_CLIP_TOP, t);
        cfg_put(CFG_CLIP_BOTTOM, bt);
        cfg_put(CFG_CLIP_DISABLE, 16'(dis));
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every expected span is out, then let a late one show up
    task automatic settle(input int tail);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Whole glyph, sometimes cut short or with ignored bytes after its end
    task automatic send_glyph(input longint gl, input longint gb, input int w, input int h,
                              input logic [15:0] col);
        int bpr;
        int total;
        int cap;
        bpr   = ((w > MAX_GLYPH_DIM ? MAX_GLYPH_DIM : w) + PIX_W - 1) / PIX_W;
        total = bpr * (h > MAX_GLYPH_DIM ? MAX_GLYPH_DIM : h);
        cap   = total;
        if (total > 48)
            cap = $urandom_range(1, 16);
        else if ($urandom_range(99) < 8)
            cap = $urandom_range(1, total);
        else if ($urandom_range(99) < 8)
            cap = total + $urandom_range(1, 3);
        for (int i = 0; i < cap; i++)
            send_byte(mk(pick_pixels(), gl, gb, w, h, col, i == 0));
    endtask

    // Mostly well-formed glyphs around a center point, some raw noise
    task automatic run_phase(input int count, input longint xc, input longint yc);
        int           goal;
        int           w;
        int           h;
        longint       gl;
        longint       gb;
        logic [95:0]  raw;
        goal = sent + count;
        while (sent < goal) begin
            if ($urandom_range(99) < 15) begin
                raw = {$urandom, $urandom, $urandom};
                send_byte(raw[$bits(t_in)-1:0]);
            end else begin
                w  = ($urandom_range(15) == 0) ? $urandom_range(MAX_GLYPH_DIM, DIM_MAX)
                                               : $urandom_range(1, 24);
                h  = ($urandom_range(15) == 0) ? $urandom_range(6, DIM_MAX)
                                               : $urandom_range(1, 5);
                if ($urandom_range(9) == 0) begin
                    gl = $signed(16'($urandom));
                    gb = $signed(16'($urandom));
                end else begin
                    gl = xc + longint'($urandom_range(64)) - 32;
                    gb = yc + longint'($urandom_range(64)) - 32;
                end
                send_glyph(gl, gb, w, h, 16'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] l;
        logic [15:0] t;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default clip rectangle after reset
        send_byte(mk(8'hF0, 5, 3, 8, 2, 16'h0000, 1'b0));       // no first byte yet
        send_byte(mk(8'hFF, 0, 0, 8, 1, 16'hFFFF, 1'b1));
        send_byte(mk(8'hFF, 0, 0, 8, 1, 16'hFFFF, 1'b0));       // past the last row
        send_byte(mk(8'hAA, 100, 200, 8, 1, 16'h1234, 1'b1));   // four spans
        send_byte(mk(8'h55, 50, 60, 16, 1, 16'h00FF, 1'b1));
        send_byte(mk(8'h55, 50, 60, 16, 1, 16'h00FF, 1'b0));    // five spans, one held
        send_byte(mk(8'h81, 0, 10, 3, 1, 16'hFF00, 1'b1));      // held span drains first
        send_byte(mk(8'hFF, 10, 10, 0, 1, 16'h0001, 1'b1));     // zero width
        send_byte(mk(8'hFF, 10, 10, 8, 1, 16'h0001, 1'b0));     // ignored
        send_byte(mk(8'hFF, 10, 10, 8, 0, 16'h0002, 1'b1));     // zero height
        send_byte(mk(8'hFF, -100, 10, 8, 1, 16'h0003, 1'b1));   // wholly outside
        send_byte(mk(8'hFF, -4, 5, 8, 1, 16'h0004, 1'b1));      // left edge cut
        for (int r = 0; r < 3; r++)                             // top row cut
            send_byte(mk(8'hFF, 0, 1, 8, 3, 16'h0005, r == 0));
        send_byte(mk(8'hFF, 0, 8000, DIM_MAX, DIM_MAX, 16'h0006, 1'b1));  // clamped size
        send_byte(mk(8'h0F, 0, 8000, DIM_MAX, DIM_MAX, 16'h0006, 1'b0));
        send_byte(mk(8'hFF, 20, 20, 24, 2, 16'h0007, 1'b1));
        send_byte(mk(8'h80, 20, 20, 8, 2, 16'h0007, 1'b0));     // width shrinks mid-row
        send_byte(mk(8'h00, 30, 30, 8, 1, 16'h0008, 1'b1));
        send_byte(mk(8'hFF, -32768, 32767, 8, 1, 16'h0009, 1'b1));
        send_byte(mk(8'hFF, 32767, 32767, 8, 1, 16'h000A, 1'b1));
        send_byte(mk(8'hFF, 32760, 100, 16, 1, 16'h000B, 1'b1));  // right clip edge
        send_byte(mk(8'hFF, 32760, 100, 16, 1, 16'h000B, 1'b0));

        // Small rectangle so glyphs straddle every edge
        settle(8);
        write_regs(-20, 40, -10, 30, 1'b0);
        run_phase(70, 10, 10);

        // Widest rectangle, no idling on either side
        settle(8);
        calm <= 1'b1;
        write_regs(-32768, 32767, -32768, 32767, 1'b0);
        run_phase(70, 32750, -32755);

        // Empty rectangle: everything hidden
        settle(8);
        calm <= 1'b0;
        write_regs(100, 100, 50, -50, 1'b0);
        run_phase(30, 100, 0);

        // Clipping off, coordinates wrap
        settle(8);
        write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        run_phase(70, 32760, -32760);

        // Random small rectangle
        settle(8);
        l = 16'($urandom_range(400)) - 16'd200;
        t = 16'($urandom_range(400)) - 16'd200;
        write_regs(l, l + 16'($urandom_range(1, 80)), t, t + 16'($urandom_range(1, 40)), 1'b0);
        run_phase(70, $signed(l), $signed(t) + 20);

        settle(20);
        if (fail_count == 0)
            $display("clipped_bitmap_span_extractor test passed");
        else
            $display("clipped_bitmap_span_extractor test failed");
        $finish;
    end

endmodule
